// File: rtl/core/sce_pkg.sv
// shared types, constants and the character map of the score code encoder
// no dependencies
package sce_pkg;

   localparam logic [7:0] CHAIN_START = 8'h69;

   // register indexes of the csr port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAME_ID    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STAMP = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_BYTE,
      S_FLUSH,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SRC_HEADER,
      SRC_VALUE,
      SRC_SUM
   } src_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       load;
      logic       step;
      src_type    src;
      logic [1:0] sel;
      logic       flush;
      logic       emit_char;
      logic       char_last;
      logic       clear;
   } ctl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic       group_full;
      logic [1:0] group_count;
      logic       out_free;
   } ctl_status_type;

   // sextet to character: A-Z a-z 0-9 + @
   function automatic logic [7:0] sextet_char(input logic [5:0] sextet);
      logic [7:0] s;
      logic [7:0] c;
      begin
         s = {2'b00, sextet};
         if (sextet < 6'd26) begin
            c = s + 8'd65;
         end else if (sextet < 6'd52) begin
            c = s + 8'd71;
         end else if (sextet < 6'd62) begin
            c = s - 8'd4;
         end else if (sextet == 6'd62) begin
            c = 8'd43;
         end else begin
            c = 8'd64;
         end
         return c;
      end
   endfunction

endpackage

// File: rtl/core/sce_datapath.sv
// datapath: csr registers, byte scrambler, group assembly and character output register
// depends on sce_pkg
module sce_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [sce_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                    csr_wdata,
   input  logic [31:0]                    req_score_value,
   input  sce_pkg::ctl_cmd_type           cmd,
   output sce_pkg::ctl_status_type        status,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_code_char,
   output logic                           rsp_last_char
);
   import sce_pkg::*;

   logic [15:0] game_id_ff, game_id_in;
   logic [15:0] time_stamp_ff, time_stamp_in;
   logic [31:0] value_ff, value_in;
   logic [7:0]  chain_ff, chain_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] group_ff, group_in;
   logic [1:0]  gcnt_ff, gcnt_in;
   logic [23:0] emit_ff, emit_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  char_ff, char_in;
   logic        last_ff, last_in;

   logic [31:0] header;
   logic [7:0]  byte_raw;
   logic [7:0]  queued;
   logic        out_free;

   assign header   = {time_stamp_ff, game_id_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // csr writes
   always_comb begin
      game_id_in    = game_id_ff;
      time_stamp_in = time_stamp_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GAME_ID:    game_id_in    = csr_wdata;
            CSR_TIME_STAMP: time_stamp_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // byte source select
   always_comb begin
      case (cmd.src)
         SRC_HEADER: byte_raw = header[{cmd.sel, 3'b000} +: 8];
         SRC_VALUE:  byte_raw = value_ff[{cmd.sel, 3'b000} +: 8];
         default:    byte_raw = sum_ff;
      endcase
   end

   // scramble, sum and group assembly
   always_comb begin
      value_in = value_ff;
      chain_in = chain_ff;
      sum_in   = sum_ff;
      group_in = group_ff;
      gcnt_in  = gcnt_ff;
      emit_in  = emit_ff;
      queued   = sum_ff;
      if (cmd.load) begin
         value_in = req_score_value;
      end
      if (cmd.step) begin
         if (cmd.src != SRC_SUM) begin
            sum_in   = sum_ff + byte_raw;
            chain_in = byte_raw ^ chain_ff;
            queued   = byte_raw ^ chain_ff;
         end
         if (gcnt_ff == 2'd2) begin
            emit_in = {group_ff, queued};
            gcnt_in = 2'd0;
         end else begin
            group_in = {group_ff[7:0], queued};
            gcnt_in  = gcnt_ff + 2'd1;
         end
      end
      if (cmd.flush) begin
         emit_in = (gcnt_ff == 2'd1) ? {group_ff[7:0], 16'h0000} : {group_ff, 8'h00};
         gcnt_in = 2'd0;
      end
      if (cmd.emit_char) begin
         emit_in = {emit_ff[17:0], 6'b000000};
      end
      if (cmd.clear) begin
         chain_in = CHAIN_START;
         sum_in   = 8'h00;
         gcnt_in  = 2'd0;
      end
   end

   // character output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (cmd.emit_char) begin
         rsp_valid_in = 1'b1;
         char_in      = sextet_char(emit_ff[23:18]);
         last_in      = cmd.char_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         game_id_ff    <= 16'h0000;
         time_stamp_ff <= 16'h0000;
         chain_ff      <= CHAIN_START;
         sum_ff        <= 8'h00;
         gcnt_ff       <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         game_id_ff    <= game_id_in;
         time_stamp_ff <= time_stamp_in;
         chain_ff      <= chain_in;
         sum_ff        <= sum_in;
         gcnt_ff       <= gcnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      group_ff <= group_in;
      emit_ff  <= emit_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign status.group_full  = (gcnt_ff == 2'd2);
   assign status.group_count = gcnt_ff;
   assign status.out_free    = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_char = char_ff;
   assign rsp_last_char = last_ff;

endmodule

// File: rtl/core/sce_control.sv
// controller: sequences header, value and sum bytes, flush and character emission
// depends on sce_pkg
module sce_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_score_bytes,
   input  logic                    req_last_score,
   input  sce_pkg::ctl_status_type status,
   output sce_pkg::ctl_cmd_type    cmd
);
   import sce_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] hdr_left_ff, hdr_left_in;
   logic [2:0] val_left_ff, val_left_in;
   logic       sum_left_ff, sum_left_in;
   logic       hdr_done_ff, hdr_done_in;
   logic [2:0] chars_left_ff, chars_left_in;
   logic       final_ff, final_in;

   logic       accept;
   logic [2:0] hdr_dec;
   logic [2:0] val_dec;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign hdr_dec   = hdr_left_ff - 3'd1;
   assign val_dec   = val_left_ff - 3'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_BYTE;
         end
         S_BYTE: begin
            if (hdr_left_ff != 3'd0 || val_left_ff != 3'd0) begin
               if (status.group_full) state_in = S_EMIT;
            end else if (sum_left_ff) begin
               state_in = status.group_full ? S_EMIT : S_FLUSH;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FLUSH: state_in = S_EMIT;
         S_EMIT: begin
            if (status.out_free && chars_left_ff == 3'd1) begin
               state_in = final_ff ? S_IDLE : S_BYTE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commands and counters
   always_comb begin
      cmd           = '0;
      cmd.src       = SRC_SUM;
      hdr_left_in   = hdr_left_ff;
      val_left_in   = val_left_ff;
      sum_left_in   = sum_left_ff;
      hdr_done_in   = hdr_done_ff;
      chars_left_in = chars_left_ff;
      final_in      = final_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load    = 1'b1;
               hdr_left_in = hdr_done_ff ? 3'd0 : 3'd4;
               hdr_done_in = 1'b1;
               val_left_in = req_score_bytes[2] ? 3'd4 : {1'b0, req_score_bytes[1:0]};
               sum_left_in = req_last_score;
            end
         end
         S_BYTE: begin
            chars_left_in = 3'd4;
            final_in      = 1'b0;
            if (hdr_left_ff != 3'd0) begin
               cmd.step    = 1'b1;
               cmd.src     = SRC_HEADER;
               cmd.sel     = hdr_dec[1:0];
               hdr_left_in = hdr_dec;
            end else if (val_left_ff != 3'd0) begin
               cmd.step    = 1'b1;
               cmd.src     = SRC_VALUE;
               cmd.sel     = val_dec[1:0];
               val_left_in = val_dec;
            end else if (sum_left_ff) begin
               cmd.step    = 1'b1;
               cmd.src     = SRC_SUM;
               sum_left_in = 1'b0;
               final_in    = 1'b1;
            end
         end
         S_FLUSH: begin
            cmd.flush     = 1'b1;
            chars_left_in = (status.group_count == 2'd1) ? 3'd2 : 3'd3;
            final_in      = 1'b1;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit_char = 1'b1;
               cmd.char_last = final_ff && (chars_left_ff == 3'd1);
               chars_left_in = chars_left_ff - 3'd1;
               if (final_ff && chars_left_ff == 3'd1) begin
                  cmd.clear   = 1'b1;
                  hdr_done_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hdr_left_ff   <= 3'd0;
         val_left_ff   <= 3'd0;
         sum_left_ff   <= 1'b0;
         hdr_done_ff   <= 1'b0;
         chars_left_ff <= 3'd0;
         final_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hdr_left_ff   <= hdr_left_in;
         val_left_ff   <= val_left_in;
         sum_left_ff   <= sum_left_in;
         hdr_done_ff   <= hdr_done_in;
         chars_left_ff <= chars_left_in;
         final_ff      <= final_in;
      end
   end

   // emission always has characters left to send
   a_emit_has_chars: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> chars_left_ff != 3'd0)
      else $error("emit state with no characters left");

   // a flush only ever sees a partial group of one or two bytes
   a_flush_partial: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |-> status.group_count != 2'd0)
      else $error("flush without a partial group");

   // a character is only loaded when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_char |-> status.out_free)
      else $error("character emitted into a busy output register");

   // the end of a code leaves the header to be sent again
   a_code_end: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> !hdr_done_ff && state_ff == S_IDLE)
      else $error("code end did not return to idle");

endmodule

// File: rtl/core/score_code_base64_encoder_top.sv
// sequence: an item is accepted, then its bytes are sent (4 header bytes on the
// first value, 0 to 4 value bytes, a sum byte on the last) and each completed group becomes
// 4 characters (2 or 3 for the final partial group); characters wait while the output is stalled
// throughput: one item at a time; a new item is taken once the previous one's bytes and
// characters have left the sequencer, with the last character waiting in the output register
// reset: synchronous, active high; chain restarts at 0x69, registers and counters clear
module score_code_base64_encoder_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [sce_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [31:0]                     req_score_value,
   input  logic [2:0]                      req_score_bytes,
   input  logic                            req_last_score,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_code_char,
   output logic                            rsp_last_char
);
   import sce_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   // byte and character sequencer
   sce_control u_control (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_score_bytes (req_score_bytes),
      .req_last_score  (req_last_score),
      .status          (status),
      .cmd             (cmd)
   );

   // scrambler, groups and output register
   sce_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_score_value (req_score_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_char   (rsp_code_char),
      .rsp_last_char   (rsp_last_char)
   );

endmodule

// File: bench/tb_score_code_base64_encoder_top.sv
`timescale 1ns / 100ps
// self-checking bench for score_code_base64_encoder_top: a directed table, then random codes
// expected characters come from an in-bench model of the byte chain, checksum and packing
// depends on sce_pkg and score_code_base64_encoder_top
module tb_score_code_base64_encoder_top;
   import sce_pkg::*;

   localparam int RANDOM_ITEMS = 360;
   localparam int DRAIN_CYCLES = 30;
   localparam int QUIET_LIMIT  = 4000;
   localparam int MAX_REPORTS  = 10;
   localparam logic [511:0] CODE_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+@";

   typedef struct packed {
      logic [7:0] code_char;
      logic       last_char;
   } code_char_type;

   typedef enum logic {
      ROW_ITEM,
      ROW_REGS
   } row_kind_type;

   // one directed row; a register row carries time_stamp in value[31:16], game_id in [15:0]
   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  value;
      logic [2:0]   nbytes;
      logic         last;
      logic [63:0]  typed;
   } row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_score_value;
   logic [2:0]  req_score_bytes;
   logic        req_last_score;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_code_char;
   logic        rsp_last_char;

   // in-bench copy of the encoder state and registers
   logic [15:0] reg_game_id;
   logic [15:0] reg_time_stamp;
   logic [7:0]  link_byte;
   logic [7:0]  check_sum;
   logic [15:0] held_bytes;
   logic [1:0]  held_count;
   logic        header_sent;

   code_char_type code_chars_due[$];
   row_type       stim_rows[$];
   code_char_type got_char;
   code_char_type due_char;
   logic          idle_on;
   int            fail_count;
   int            quiet_cycles;
   int            stall_left;
   int            stall_pick;

   score_code_base64_encoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_score_value (req_score_value),
      .req_score_bytes (req_score_bytes),
      .req_last_score  (req_last_score),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_char   (rsp_code_char),
      .rsp_last_char   (rsp_last_char)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // character model
   function automatic void push_sextet(input logic [5:0] sextet);
      code_char_type c;
      int unsigned   pos;
      pos = 63 - sextet;
      c.code_char = CODE_ALPHABET[8*pos +: 8];
      c.last_char = 1'b0;
      code_chars_due.push_back(c);
   endfunction

   function automatic void pack_byte(input logic [7:0] b);
      logic [23:0] grp;
      if (held_count == 2'd2) begin
         grp = {held_bytes, b};
         push_sextet(grp[23:18]);
         push_sextet(grp[17:12]);
         push_sextet(grp[11:6]);
         push_sextet(grp[5:0]);
         held_bytes = 16'h0000;
         held_count = 2'd0;
      end else begin
         held_bytes = {held_bytes[7:0], b};
         held_count = held_count + 2'd1;
      end
   endfunction

   function automatic void scramble_byte(input logic [7:0] b);
      check_sum = check_sum + b;
      link_byte = link_byte ^ b;
      pack_byte(link_byte);
   endfunction

   function automatic void restart_code();
      link_byte   = CHAIN_START;
      check_sum   = 8'h00;
      held_bytes  = 16'h0000;
      held_count  = 2'd0;
      header_sent = 1'b0;
   endfunction

   // appends the characters one accepted value causes
   function automatic void predict_code_item(input logic [31:0] value, input logic [2:0] nbytes,
                                             input logic last);
      int            n;
      int            j;
      code_char_type tail;
      n = (nbytes > 3'd4) ? 4 : int'(nbytes);
      if (!header_sent) begin
         scramble_byte(reg_time_stamp[15:8]);
         scramble_byte(reg_time_stamp[7:0]);
         scramble_byte(reg_game_id[15:8]);
         scramble_byte(reg_game_id[7:0]);
         header_sent = 1'b1;
      end
      for (j = n; j > 0; j--) begin
         scramble_byte(value[8*(j-1) +: 8]);
      end
      if (last) begin
         pack_byte(check_sum);
         // partial group: drop the characters made only of padding
         if (held_count == 2'd1) begin
            push_sextet(held_bytes[7:2]);
            push_sextet({held_bytes[1:0], 4'b0000});
         end else if (held_count == 2'd2) begin
            push_sextet(held_bytes[15:10]);
            push_sextet(held_bytes[9:4]);
            push_sextet({held_bytes[3:0], 2'b00});
         end
         tail = code_chars_due.pop_back();
         tail.last_char = 1'b1;
         code_chars_due.push_back(tail);
         restart_code();
      end
   endfunction

   task automatic add_row(input row_kind_type kind, input logic [31:0] value,
                          input logic [2:0] nbytes, input logic last, input logic [63:0] typed);
      row_type r;
      r.kind   = kind;
      r.value  = value;
      r.nbytes = nbytes;
      r.last   = last;
      r.typed  = typed;
      stim_rows.push_back(r);
   endtask

   // register write, only while the encoder is idle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [15:0] data);
      csr_write = 1'b1;
      csr_index = index;
      csr_wdata = data;
      if (index == CSR_GAME_ID) begin
         reg_game_id = data;
      end else begin
         reg_time_stamp = data;
      end
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // hold off until every due character has arrived, then let the block settle
   task automatic wait_drained();
      req_valid = 1'b0;
      while (code_chars_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic sender_gap();
      int n;
      int r;
      n = 0;
      r = $urandom_range(0, 99);
      if (idle_on) begin
         if (r >= 90) begin
            n = $urandom_range(8, 40);
         end else if (r >= 55) begin
            n = $urandom_range(1, 3);
         end
      end
      if (n > 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // one input transfer; a nonzero typed string replaces the modeled characters
   task automatic send_item(input logic [31:0] value, input logic [2:0] nbytes,
                            input logic last, input logic [63:0] typed);
      int            base;
      int            k;
      logic [7:0]    ch;
      code_char_type c;
      req_score_value = value;
      req_score_bytes = nbytes;
      req_last_score  = last;
      req_valid       = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      base = code_chars_due.size();
      predict_code_item(value, nbytes, last);
      if (typed != 64'h0) begin
         while (code_chars_due.size() > base) c = code_chars_due.pop_back();
         for (k = 7; k >= 0; k--) begin
            ch = typed[8*k +: 8];
            if (ch != 8'h00) begin
               c.code_char = ch;
               c.last_char = 1'b0;
               code_chars_due.push_back(c);
            end
         end
         c = code_chars_due.pop_back();
         c.last_char = last;
         code_chars_due.push_back(c);
      end
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hFFFF_FFFF;
      if (r == 2) return 32'h1 << $urandom_range(0, 31);
      return $urandom;
   endfunction

   function automatic logic [2:0] rand_nbytes();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 3'd0;
      if (r == 1) return 3'($urandom_range(5, 7));
      return 3'($urandom_range(1, 4));
   endfunction

   function automatic logic [15:0] rand_reg();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // result side: random stall runs, mostly short with a few long ones
   always @(negedge clock) begin
      if (!idle_on) begin
         rsp_stall = 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall = 1'b0;
         stall_left = $urandom_range(0, 20);
      end else begin
         rsp_stall = 1'b1;
         stall_pick = $urandom_range(0, 99);
         stall_left = (stall_pick < 85) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
   end

   // compare each output transfer with the oldest due character
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_char.code_char = rsp_code_char;
         got_char.last_char = rsp_last_char;
         if (code_chars_due.size() == 0) begin
            fail_count = fail_count + 1;
            if (fail_count <= MAX_REPORTS) begin
               $display("unexpected char %h last %b at %0t", rsp_code_char, rsp_last_char,
                        $realtime);
            end
         end else begin
            due_char = code_chars_due.pop_front();
            if (due_char !== got_char) begin
               fail_count = fail_count + 1;
               if (fail_count <= MAX_REPORTS) begin
                  $display("char mismatch at %0t: expected %h last %b, got %h last %b",
                           $realtime, due_char.code_char, due_char.last_char,
                           rsp_code_char, rsp_last_char);
               end
            end
         end
      end
   end

   // watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      row_type rw;
      int      i;
      int      k;
      int      sent;
      int      code_len;
      reset           = 1'b1;
      csr_write       = 1'b0;
      csr_index       = CSR_GAME_ID;
      csr_wdata       = 16'h0000;
      req_valid       = 1'b0;
      req_score_value = 32'h0;
      req_score_bytes = 3'd0;
      req_last_score  = 1'b0;
      rsp_stall       = 1'b0;
      idle_on         = 1'b1;
      fail_count      = 0;
      quiet_cycles    = 0;
      stall_left      = 0;
      reg_game_id     = 16'h0000;
      reg_time_stamp  = 16'h0000;
      restart_code();

      // after reset: zero registers, so the header is four chained 0x69 bytes
      add_row(ROW_ITEM, 32'h0000_0000, 3'd0, 1'b1, "aWlpaQA");
      add_row(ROW_ITEM, 32'h0000_0000, 3'd1, 1'b1, "aWlpaWkA");
      add_row(ROW_REGS, 32'hFFFF_FFFF, 3'd0, 1'b0, 64'h0);
      add_row(ROW_ITEM, 32'hFFFF_FFFF, 3'd4, 1'b1, 64'h0);
      add_row(ROW_ITEM, 32'hFFFF_FFFF, 3'd7, 1'b1, 64'h0);
      add_row(ROW_ITEM, 32'h1234_5678, 3'd5, 1'b0, 64'h0);
      add_row(ROW_ITEM, 32'h9ABC_DEF0, 3'd6, 1'b0, 64'h0);
      add_row(ROW_ITEM, 32'h0000_0000, 3'd0, 1'b0, 64'h0);
      add_row(ROW_ITEM, 32'hA5A5_A5A5, 3'd3, 1'b1, 64'h0);
      add_row(ROW_REGS, 32'hFFFF_0000, 3'd0, 1'b0, 64'h0);
      add_row(ROW_ITEM, 32'h0000_00FF, 3'd2, 1'b0, 64'h0);
      add_row(ROW_ITEM, 32'h8000_0001, 3'd4, 1'b1, 64'h0);
      add_row(ROW_ITEM, 32'hFFFF_FFFF, 3'd1, 1'b1, 64'h0);
      add_row(ROW_ITEM, 32'h0000_0000, 3'd4, 1'b1, 64'h0);
      add_row(ROW_ITEM, 32'hFFFF_0000, 3'd3, 1'b1, 64'h0);
      add_row(ROW_ITEM, 32'h0000_005A, 3'd2, 1'b1, 64'h0);
      add_row(ROW_REGS, 32'h0000_FFFF, 3'd0, 1'b0, 64'h0);
      add_row(ROW_ITEM, 32'h0123_4567, 3'd1, 1'b0, 64'h0);
      add_row(ROW_ITEM, 32'h89AB_CDEF, 3'd2, 1'b0, 64'h0);
      add_row(ROW_ITEM, 32'h7654_3210, 3'd3, 1'b0, 64'h0);
      add_row(ROW_ITEM, 32'hFEDC_BA98, 3'd4, 1'b0, 64'h0);
      add_row(ROW_ITEM, 32'h5555_5555, 3'd1, 1'b0, 64'h0);
      add_row(ROW_ITEM, 32'hAAAA_AAAA, 3'd2, 1'b1, 64'h0);

      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed table
      for (i = 0; i < stim_rows.size(); i++) begin
         rw = stim_rows[i];
         if (rw.kind == ROW_REGS) begin
            wait_drained();
            write_reg(CSR_GAME_ID, rw.value[15:0]);
            write_reg(CSR_TIME_STAMP, rw.value[31:16]);
         end else begin
            sender_gap();
            send_item(rw.value, rw.nbytes, rw.last, rw.typed);
         end
      end

      // random codes, mostly short, now and then long
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            wait_drained();
            write_reg(CSR_GAME_ID, rand_reg());
            write_reg(CSR_TIME_STAMP, rand_reg());
         end else if ($urandom_range(0, 11) == 0) begin
            wait_drained();
         end
         if ($urandom_range(0, 5) == 0) begin
            idle_on = !idle_on;
         end
         code_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
         for (k = 0; k < code_len; k++) begin
            sender_gap();
            send_item(rand_value(), rand_nbytes(), k == code_len - 1, 64'h0);
            sent = sent + 1;
         end
      end

      idle_on = 1'b1;
      wait_drained();
      if (fail_count == 0 && code_chars_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
